// ===== design/smits_pkg.sv =====
package smits_pkg;

  // Channel and bin formats.
  localparam int CH_W      = 16;
  localparam int NUM_BINS  = 10;
  localparam int BIN_W     = 17;
  localparam int BASIS_W   = 17;
  localparam int NUM_BASES = 7;
  localparam int PROD_W    = CH_W + BASIS_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RND_W     = SUM_W - CH_W;
  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

  // Basis selector codes.
  typedef enum logic [2:0] {
    B_WHITE   = 3'd0,
    B_RED     = 3'd1,
    B_YELLOW  = 3'd2,
    B_GREEN   = 3'd3,
    B_CYAN    = 3'd4,
    B_BLUE    = 3'd5,
    B_MAGENTA = 3'd6
  } basis_t;

  // Basis spectra, unsigned Q1.16, one row per basis in selector order.
  localparam logic [BASIS_W-1:0] BASIS [0:NUM_BASES-1][0:NUM_BINS-1] = '{
    '{17'd65536, 17'd65536, 17'd65529, 17'd65490, 17'd65484,
      17'd65523, 17'd65536, 17'd65536, 17'd65536, 17'd65536},
    '{17'd6632,  17'd3375,  17'd0,     17'd0,     17'd0,
      17'd0,     17'd54559, 17'd66512, 17'd66512, 17'd66512},
    '{17'd7,     17'd0,     17'd7130,  17'd43588, 17'd65536,
      17'd65536, 17'd65510, 17'd62823, 17'd63472, 17'd64487},
    '{17'd0,     17'd0,     17'd1789,  17'd52016, 17'd65536,
      17'd61722, 17'd11266, 17'd0,     17'd0,     17'd164},
    '{17'd63635, 17'd61774, 17'd65582, 17'd65582, 17'd65582,
      17'd65582, 17'd10250, 17'd0,     17'd0,     17'd0},
    '{17'd65536, 17'd65536, 17'd58432, 17'd21778, 17'd0,
      17'd0,     17'd20,    17'd2418,  17'd3165,  17'd3251},
    '{17'd65536, 17'd65536, 17'd63472, 17'd14608, 17'd0,
      17'd3002,  17'd54846, 17'd65536, 17'd65536, 17'd65267}
  };

  // Input pixel transaction.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } smits_in_t;

  // Result spectrum transaction.
  typedef struct packed {
    logic [BIN_W-1:0] bin_0;
    logic [BIN_W-1:0] bin_1;
    logic [BIN_W-1:0] bin_2;
    logic [BIN_W-1:0] bin_3;
    logic [BIN_W-1:0] bin_4;
    logic [BIN_W-1:0] bin_5;
    logic [BIN_W-1:0] bin_6;
    logic [BIN_W-1:0] bin_7;
    logic [BIN_W-1:0] bin_8;
    logic [BIN_W-1:0] bin_9;
  } smits_out_t;

  // Mixing weights and basis choice handed from the sorter to the mixer.
  typedef struct packed {
    logic [CH_W-1:0] base;
    logic [CH_W-1:0] gap1;
    logic [CH_W-1:0] gap2;
    basis_t          sec;
    basis_t          pri;
  } mix_ctl_t;

endpackage

// ===== design/smits_sort.sv =====
module smits_sort (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pix_valid,
  input  smits_pkg::smits_in_t pix,
  output logic                 ctl_valid,
  output smits_pkg::mix_ctl_t  ctl
);
  import smits_pkg::*;

  logic     ctl_valid_r;
  mix_ctl_t ctl_r;
  mix_ctl_t ctl_nxt;
  logic     r_le_g, r_le_b, g_le_b;

  // Pairwise compares shared by all branches.
  assign r_le_g = (pix.red   <= pix.green);
  assign r_le_b = (pix.red   <= pix.blue);
  assign g_le_b = (pix.green <= pix.blue);

  // Pick the minimum with ties going to red, then green; then order the other two.
  always_comb begin
    ctl_nxt = '0;
    priority if (r_le_g && r_le_b) begin
      ctl_nxt.base = pix.red;
      ctl_nxt.sec  = B_CYAN;
      if (!g_le_b) begin
        ctl_nxt.gap1 = pix.blue  - pix.red;
        ctl_nxt.gap2 = pix.green - pix.blue;
        ctl_nxt.pri  = B_GREEN;
      end else begin
        ctl_nxt.gap1 = pix.green - pix.red;
        ctl_nxt.gap2 = pix.blue  - pix.green;
        ctl_nxt.pri  = B_BLUE;
      end
    end else if (!r_le_g && g_le_b) begin
      ctl_nxt.base = pix.green;
      ctl_nxt.sec  = B_MAGENTA;
      if (!r_le_b) begin
        ctl_nxt.gap1 = pix.blue - pix.green;
        ctl_nxt.gap2 = pix.red  - pix.blue;
        ctl_nxt.pri  = B_RED;
      end else begin
        ctl_nxt.gap1 = pix.red  - pix.green;
        ctl_nxt.gap2 = pix.blue - pix.red;
        ctl_nxt.pri  = B_BLUE;
      end
    end else begin
      ctl_nxt.base = pix.blue;
      ctl_nxt.sec  = B_YELLOW;
      if (!r_le_g) begin
        ctl_nxt.gap1 = pix.green - pix.blue;
        ctl_nxt.gap2 = pix.red   - pix.green;
        ctl_nxt.pri  = B_RED;
      end else begin
        ctl_nxt.gap1 = pix.red   - pix.blue;
        ctl_nxt.gap2 = pix.green - pix.red;
        ctl_nxt.pri  = B_GREEN;
      end
    end
  end

  // Stage register for the mixing weights.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_valid_r <= 1'b0;
    end else begin
      ctl_valid_r <= pix_valid;
    end
    ctl_r <= ctl_nxt;
  end

  assign ctl_valid = ctl_valid_r;
  assign ctl       = ctl_r;

`ifndef SYNTHESIS
  // The secondary basis is always cyan, magenta or yellow.
  a_sec_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_valid_r |-> (ctl_r.sec == B_CYAN || ctl_r.sec == B_MAGENTA ||
                     ctl_r.sec == B_YELLOW))
    else $error("secondary basis is not cyan, magenta or yellow");

  // The primary basis never lies opposite the secondary one.
  a_pri_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_valid_r |-> !((ctl_r.sec == B_CYAN    && ctl_r.pri == B_RED)   ||
                      (ctl_r.sec == B_MAGENTA && ctl_r.pri == B_GREEN) ||
                      (ctl_r.sec == B_YELLOW  && ctl_r.pri == B_BLUE)))
    else $error("primary basis pairs with its complementary secondary");
`endif

endmodule

// ===== design/smits_mix.sv =====
module smits_mix (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ctl_valid,
  input  smits_pkg::mix_ctl_t   ctl,
  output logic                  res_valid,
  output smits_pkg::smits_out_t res
);
  import smits_pkg::*;

  logic              prod_valid_r;
  logic [PROD_W-1:0] pw_r  [NUM_BINS];
  logic [PROD_W-1:0] p1_r  [NUM_BINS];
  logic [PROD_W-1:0] p2_r  [NUM_BINS];
  logic [PROD_W-1:0] pw_nxt[NUM_BINS];
  logic [PROD_W-1:0] p1_nxt[NUM_BINS];
  logic [PROD_W-1:0] p2_nxt[NUM_BINS];
  logic [SUM_W-1:0]  sum   [NUM_BINS];
  logic [RND_W-1:0]  rnd   [NUM_BINS];
  logic [BIN_W-1:0]  bin_nxt[NUM_BINS];
  logic              res_valid_r;
  smits_out_t        res_r;
  smits_out_t        res_nxt;

  // Three products per bin: white, secondary and primary basis scaled by their weights.
  always_comb begin
    for (int i = 0; i < NUM_BINS; i++) begin
      pw_nxt[i] = PROD_W'(ctl.base) * PROD_W'(BASIS[B_WHITE][i]);
      p1_nxt[i] = PROD_W'(ctl.gap1) * PROD_W'(BASIS[ctl.sec][i]);
      p2_nxt[i] = PROD_W'(ctl.gap2) * PROD_W'(BASIS[ctl.pri][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= ctl_valid;
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      pw_r[i] <= pw_nxt[i];
      p1_r[i] <= p1_nxt[i];
      p2_r[i] <= p2_nxt[i];
    end
  end

  // Exact sum, round half up to Q1.16 and saturate.
  always_comb begin
    for (int i = 0; i < NUM_BINS; i++) begin
      sum[i] = SUM_W'(pw_r[i]) + SUM_W'(p1_r[i]) + SUM_W'(p2_r[i])
             + (SUM_W'(1) << (CH_W - 1));
      rnd[i] = sum[i][SUM_W-1:CH_W];
      if (rnd[i] > RND_W'(BIN_MAX)) begin
        bin_nxt[i] = BIN_MAX;
      end else begin
        bin_nxt[i] = rnd[i][BIN_W-1:0];
      end
    end
  end

  always_comb begin
    res_nxt.bin_0 = bin_nxt[0];
    res_nxt.bin_1 = bin_nxt[1];
    res_nxt.bin_2 = bin_nxt[2];
    res_nxt.bin_3 = bin_nxt[3];
    res_nxt.bin_4 = bin_nxt[4];
    res_nxt.bin_5 = bin_nxt[5];
    res_nxt.bin_6 = bin_nxt[6];
    res_nxt.bin_7 = bin_nxt[7];
    res_nxt.bin_8 = bin_nxt[8];
    res_nxt.bin_9 = bin_nxt[9];
  end

  // Result register and its strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= prod_valid_r;
    end
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== design/rgb_to_spectrum_smits_top.sv =====
// RGB to 10-bin reflectance spectrum, one pixel per transaction.
// The out_valid strobe follows an accepted start through the input, sort, product and result registers.
// Throughput: one pixel every cycle; busy is never raised, as there is no iterative unit.
// Stages: input register, sort, products, sum/round/saturate into the result register.
// Reset clears only the valid flags; each result is shown for exactly one cycle.
module rgb_to_spectrum_smits_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  smits_pkg::smits_in_t  in_pixel,
  output logic                  out_valid,
  output smits_pkg::smits_out_t out_result
);
  import smits_pkg::*;

  logic       in_valid_r;
  smits_in_t  in_pix_r;
  logic       ctl_valid;
  mix_ctl_t   ctl;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    in_pix_r <= in_pixel;
  end

  smits_sort u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (in_valid_r),
    .pix       (in_pix_r),
    .ctl_valid (ctl_valid),
    .ctl       (ctl)
  );

  smits_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_valid (ctl_valid),
    .ctl       (ctl),
    .res_valid (out_valid),
    .res       (out_result)
  );

`ifndef SYNTHESIS
  // Every accepted pixel produces a result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 out_valid)
    else $error("accepted pixel did not produce a result");

  // No result appears without a matching accepted pixel.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4))
    else $error("result strobe without a matching transaction");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;
  import smits_pkg::*;

  // Reflectance tables, unsigned Q1.16, rows in basis selector order.
  localparam int unsigned REFLECT_TABLE [0:NUM_BASES-1][0:NUM_BINS-1] = '{
    '{65536, 65536, 65529, 65490, 65484, 65523, 65536, 65536, 65536, 65536},
    '{6632,  3375,  0,     0,     0,     0,     54559, 66512, 66512, 66512},
    '{7,     0,     7130,  43588, 65536, 65536, 65510, 62823, 63472, 64487},
    '{0,     0,     1789,  52016, 65536, 61722, 11266, 0,     0,     164},
    '{63635, 61774, 65582, 65582, 65582, 65582, 10250, 0,     0,     0},
    '{65536, 65536, 58432, 21778, 0,     0,     20,    2418,  3165,  3251},
    '{65536, 65536, 63472, 14608, 0,     3002,  54846, 65536, 65536, 65267}
  };

  typedef struct {
    smits_in_t pixel;
    bit        drain_first;
  } pending_pixel_t;

  typedef struct {
    smits_in_t  pixel;
    smits_out_t spectrum;
  } expected_spectrum_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  smits_in_t  in_pixel;
  logic       out_valid;
  smits_out_t out_result;

  pending_pixel_t     pixel_queue[$];
  expected_spectrum_t spectrum_queue[$];
  int                 mismatch_count = 0;
  logic               took = 1'b0;
  int                 gap_left = 0;
  int                 stretch_left = 0;
  bit                 calm_stretch = 1'b0;

  rgb_to_spectrum_smits_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // Expected spectrum of one pixel: white scaled by the minimum, then the
  // secondary and primary bases scaled by the two gaps above it.
  function automatic smits_out_t predict_spectrum(smits_in_t px);
    longint unsigned r, g, b, base, gap1, gap2, acc;
    basis_t sec, pri;
    logic [NUM_BINS*BIN_W-1:0] spec;
    r = px.red;
    g = px.green;
    b = px.blue;
    if (r <= g && r <= b) begin
      base = r;
      sec  = B_CYAN;
      if (g < b) begin
        gap1 = g - r; gap2 = b - g; pri = B_BLUE;
      end else begin
        gap1 = b - r; gap2 = g - b; pri = B_GREEN;
      end
    end else if (g <= r && g <= b) begin
      base = g;
      sec  = B_MAGENTA;
      if (r < b) begin
        gap1 = r - g; gap2 = b - r; pri = B_BLUE;
      end else begin
        gap1 = b - g; gap2 = r - b; pri = B_RED;
      end
    end else begin
      base = b;
      sec  = B_YELLOW;
      if (r < g) begin
        gap1 = r - b; gap2 = g - r; pri = B_GREEN;
      end else begin
        gap1 = g - b; gap2 = r - g; pri = B_RED;
      end
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      acc = base * REFLECT_TABLE[B_WHITE][i] + gap1 * REFLECT_TABLE[sec][i]
          + gap2 * REFLECT_TABLE[pri][i];
      acc = (acc + (64'd1 << (CH_W - 1))) >> CH_W;
      if (acc > BIN_MAX) begin
        acc = BIN_MAX;
      end
      spec[(NUM_BINS-1-i)*BIN_W +: BIN_W] = acc[BIN_W-1:0];
    end
    return smits_out_t'(spec);
  endfunction

  // Idle cycles before the next pixel: stretches without gaps are mixed at random
  // with stretches of mostly short and a few long gaps.
  function automatic int next_gap();
    int roll;
    if (stretch_left == 0) begin
      calm_stretch = ($urandom_range(0, 3) == 0);
      stretch_left = $urandom_range(10, 60);
    end
    stretch_left--;
    if (calm_stretch) begin
      return 0;
    end
    roll = $urandom_range(0, 19);
    if (roll < 10) begin
      return 0;
    end else if (roll < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CH_W-1:0] edge_value();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'd1;
      2: return 16'hfffe;
      default: return 16'hffff;
    endcase
  endfunction

  // Random pixel, weighted towards ties, extremes and near-equal channels.
  function automatic smits_in_t random_pixel();
    smits_in_t px;
    logic [CH_W-1:0] v;
    int kind;
    kind = $urandom_range(0, 9);
    px.red   = CH_W'($urandom_range(0, 65535));
    px.green = CH_W'($urandom_range(0, 65535));
    px.blue  = CH_W'($urandom_range(0, 65535));
    case (kind)
      5: begin
        case ($urandom_range(0, 2))
          0: px.green = px.red;
          1: px.blue  = px.red;
          default: px.blue = px.green;
        endcase
      end
      6: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      7: begin
        px.red   = edge_value();
        px.green = edge_value();
        px.blue  = edge_value();
      end
      8: begin
        px.red   = CH_W'($urandom_range(0, 255));
        px.green = CH_W'($urandom_range(0, 255));
        px.blue  = CH_W'($urandom_range(0, 255));
      end
      9: begin
        v = CH_W'($urandom_range(4, 65531));
        px.red   = CH_W'(v + $urandom_range(0, 4) - 2);
        px.green = CH_W'(v + $urandom_range(0, 4) - 2);
        px.blue  = CH_W'(v + $urandom_range(0, 4) - 2);
      end
      default: begin
      end
    endcase
    return px;
  endfunction

  task automatic add_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                           bit drain_first);
    pending_pixel_t item;
    item.pixel.red   = r;
    item.pixel.green = g;
    item.pixel.blue  = b;
    item.drain_first = drain_first;
    pixel_queue.push_back(item);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: presents the next pixel at the falling edge once the previous
  // transaction has been taken, honouring gaps and drain requests.
  always @(negedge clk) begin
    logic           next_start;
    pending_pixel_t item;
    if (!rst_n) begin
      start    <= 1'b0;
      in_pixel <= '0;
    end else if (start && !took) begin
      // Transaction not yet taken: the current pixel stays on the port.
    end else begin
      next_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pixel_queue.size() != 0 &&
                   !(pixel_queue[0].drain_first && spectrum_queue.size() != 0)) begin
        item = pixel_queue.pop_front();
        in_pixel <= item.pixel;
        next_start = 1'b1;
        gap_left = next_gap();
      end
      start <= next_start;
    end
  end

  // Monitor: checks each spectrum strobe against the oldest prediction,
  // then records the pixel transaction accepted at this edge.
  always @(posedge clk) begin
    expected_spectrum_t want;
    logic [NUM_BINS*BIN_W-1:0] want_vec, got_vec;
    if (rst_n) begin
      if (out_valid) begin
        if (spectrum_queue.size() == 0) begin
          $display("%0t: unexpected spectrum, expected none, got %h", $time, out_result);
          mismatch_count++;
        end else begin
          want = spectrum_queue.pop_front();
          want_vec = want.spectrum;
          got_vec  = out_result;
          for (int i = 0; i < NUM_BINS; i++) begin
            if (got_vec[(NUM_BINS-1-i)*BIN_W +: BIN_W] !==
                want_vec[(NUM_BINS-1-i)*BIN_W +: BIN_W]) begin
              $display("%0t: pixel %h bin_%0d expected %h got %h", $time, want.pixel, i,
                       want_vec[(NUM_BINS-1-i)*BIN_W +: BIN_W],
                       got_vec[(NUM_BINS-1-i)*BIN_W +: BIN_W]);
              mismatch_count++;
            end
          end
        end
      end
      if (start && !busy) begin
        want.pixel    = in_pixel;
        want.spectrum = predict_spectrum(in_pixel);
        spectrum_queue.push_back(want);
      end
      took <= start && !busy;
    end
  end

  // Stimulus and end of run.
  initial begin
    rst_n    = 1'b0;

    // Extremes, every ordering of the channels and every kind of tie.
    add_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_pixel(16'hffff, 16'hffff, 16'hffff, 1'b0);
    add_pixel(16'hffff, 16'h0000, 16'h0000, 1'b0);
    add_pixel(16'h0000, 16'hffff, 16'h0000, 1'b0);
    add_pixel(16'h0000, 16'h0000, 16'hffff, 1'b0);
    add_pixel(16'hffff, 16'hffff, 16'h0000, 1'b0);
    add_pixel(16'hffff, 16'h0000, 16'hffff, 1'b0);
    add_pixel(16'h0000, 16'hffff, 16'hffff, 1'b0);
    add_pixel(16'h1000, 16'h2000, 16'h3000, 1'b0);
    add_pixel(16'h1000, 16'h3000, 16'h2000, 1'b0);
    add_pixel(16'h2000, 16'h1000, 16'h3000, 1'b0);
    add_pixel(16'h3000, 16'h1000, 16'h2000, 1'b0);
    add_pixel(16'h2000, 16'h3000, 16'h1000, 1'b0);
    add_pixel(16'h3000, 16'h2000, 16'h1000, 1'b0);
    add_pixel(16'h4000, 16'h4000, 16'h9000, 1'b0);
    add_pixel(16'h4000, 16'h9000, 16'h4000, 1'b0);
    add_pixel(16'h9000, 16'h4000, 16'h4000, 1'b0);
    add_pixel(16'h9000, 16'h9000, 16'h4000, 1'b0);
    add_pixel(16'h9000, 16'h4000, 16'h9000, 1'b0);
    add_pixel(16'h4000, 16'h9000, 16'h9000, 1'b0);
    add_pixel(16'h8000, 16'h8000, 16'h8000, 1'b0);
    add_pixel(16'haaaa, 16'h5555, 16'haaaa, 1'b0);
    add_pixel(16'h5555, 16'haaaa, 16'h5555, 1'b0);
    add_pixel(16'h0001, 16'h0000, 16'hffff, 1'b0);

    // Random part; a few pixels wait until the pipeline has drained.
    for (int n = 0; n < 450; n++) begin
      pending_pixel_t item;
      item.pixel       = random_pixel();
      item.drain_first = (n == 0 || n == 200 || n == 350);
      pixel_queue.push_back(item);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pixel_queue.size() != 0 || start || spectrum_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (spectrum_queue.size() != 0) begin
      $display("%0t: %0d spectra expected, got none", $time, spectrum_queue.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog against a hung pipeline.
  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

endmodule
